@@ hdl/sha256_pkg.sv @@
// Shared types, constants and schedule functions for the SHA-256 byte-stream hasher.
// No dependencies; used by sha256_round and the top level.
package sha256_pkg;

  localparam int unsigned WordW = 32;

  typedef logic [WordW-1:0] word_t;

  // Initial hash value for digest word i.
  function automatic word_t init_hash(input logic [2:0] i);
    word_t r;
    case (i)
      3'd0: r = 32'h6A09E667;
      3'd1: r = 32'hBB67AE85;
      3'd2: r = 32'h3C6EF372;
      3'd3: r = 32'hA54FF53A;
      3'd4: r = 32'h510E527F;
      3'd5: r = 32'h9B05688C;
      3'd6: r = 32'h1F83D9AB;
      default: r = 32'h5BE0CD19;
    endcase
    return r;
  endfunction

  // Round constant for round t.
  function automatic word_t round_k(input logic [5:0] t);
    word_t r;
    case (t)
      6'd0: r = 32'h428a2f98; 6'd1: r = 32'h71374491; 6'd2: r = 32'hb5c0fbcf;
      6'd3: r = 32'he9b5dba5; 6'd4: r = 32'h3956c25b; 6'd5: r = 32'h59f111f1;
      6'd6: r = 32'h923f82a4; 6'd7: r = 32'hab1c5ed5; 6'd8: r = 32'hd807aa98;
      6'd9: r = 32'h12835b01; 6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
      6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe; 6'd14: r = 32'h9bdc06a7;
      6'd15: r = 32'hc19bf174; 6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
      6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc; 6'd20: r = 32'h2de92c6f;
      6'd21: r = 32'h4a7484aa; 6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
      6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d; 6'd26: r = 32'hb00327c8;
      6'd27: r = 32'hbf597fc7; 6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
      6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967; 6'd32: r = 32'h27b70a85;
      6'd33: r = 32'h2e1b2138; 6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
      6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb; 6'd38: r = 32'h81c2c92e;
      6'd39: r = 32'h92722c85; 6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
      6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3; 6'd44: r = 32'hd192e819;
      6'd45: r = 32'hd6990624; 6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
      6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08; 6'd50: r = 32'h2748774c;
      6'd51: r = 32'h34b0bcb5; 6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
      6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3; 6'd56: r = 32'h748f82ee;
      6'd57: r = 32'h78a5636f; 6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
      6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb; 6'd62: r = 32'hbef9a3f7;
      default: r = 32'hc67178f2;
    endcase
    return r;
  endfunction

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (WordW - n));
  endfunction

  function automatic word_t sig0(input word_t x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t sig1(input word_t x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  // Working variables a..h as one bundle.
  typedef struct packed {
    word_t a, b, c, d, e, f, g, h;
  } vars_t;

endpackage

@@ hdl/sha256_round.sv @@
// One SHA-256 compression round on the working variables.
// Depends on sha256_pkg for the word types and rotate helper.
module sha256_round (
  input  sha256_pkg::vars_t v,
  input  sha256_pkg::word_t k,
  input  sha256_pkg::word_t w,
  output sha256_pkg::vars_t v_next
);

  sha256_pkg::word_t t1;
  sha256_pkg::word_t t2;

  // Two temporaries, then shift the variables down by one.
  always_comb begin
    t1 = v.h + (sha256_pkg::rotr(v.e, 6) ^ sha256_pkg::rotr(v.e, 11) ^
         sha256_pkg::rotr(v.e, 25)) + ((v.e & v.f) ^ (~v.e & v.g)) + k + w;
    t2 = (sha256_pkg::rotr(v.a, 2) ^ sha256_pkg::rotr(v.a, 13) ^
         sha256_pkg::rotr(v.a, 22)) + ((v.a & v.b) ^ (v.a & v.c) ^ (v.b & v.c));
    v_next.h = v.g;
    v_next.g = v.f;
    v_next.f = v.e;
    v_next.e = v.d + t1;
    v_next.d = v.c;
    v_next.c = v.b;
    v_next.b = v.a;
    v_next.a = t1 + t2;
  end

endmodule

@@ hdl/sha256_byte_stream_hasher_core.sv @@
// Top level of the SHA-256 byte-stream hasher: byte packing, padding, schedule memory,
// hash memory and digest output. Depends on sha256_pkg and sha256_round.
//
//  channel | signals                                   | direction
//  in      | in_valid, in_stall, data_byte, has_byte, last | word in
//  out     | out_valid, out_stall, digest_word, word_index, final_word | word out
//
// A byte is written into the block in the cycle it is accepted. For a full block the hash
// memory is loaded into the working variables (a read step and a load step per word), the
// rounds run (each with four schedule memory reads of w[t-2], w[t-7], w[t-15] and w[t],
// then the round) and the working variables are added back; the single schedule memory
// read port sets this sequence. Padding writes one byte per cycle. Each digest word is
// read in S_HRD, then shown in S_OUT until taken. Reset is synchronous and returns to
// the initial hash. Input stall is high whenever the block is not waiting for a byte;
// the digest waits in the output register while out_stall is high.
module sha256_byte_stream_hasher_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        has_byte,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        final_word
);

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_LOADW, S_RD1, S_RD2, S_RD3, S_RD4, S_ROUND, S_ADD, S_ADDW,
    S_PAD, S_HRD, S_OUT
  } state_t;

  state_t state;
  // Schedule memory: block words, then the rolling message schedule.
  sha256_pkg::word_t wmem [16];
  // Hash memory: running hash H0..H7, with a valid bit per entry for the reset value.
  sha256_pkg::word_t hmem [8];
  logic [7:0] hvalid;

  logic [5:0]  fill;
  logic [60:0] msg_bytes;
  logic        finishing;
  logic [3:0]  pad_cnt;  // bytes of length field written, counts 0..8
  logic        pad_first;
  // Set when the 0x80 byte landed too late for the length; the rest of this block is zero.
  logic        pad_spill;
  logic [5:0]  rnd;
  logic [2:0]  hidx;
  sha256_pkg::vars_t v;
  sha256_pkg::vars_t v_next;
  sha256_pkg::word_t w_cur, w2, w7, w15, w16;
  sha256_pkg::word_t rdata;
  sha256_pkg::word_t hdata;
  logic        hval_q;
  logic [31:0] word_buf;

  // Byte writer: up to one byte per cycle, from the input while idle or from padding.
  logic       bwr;
  logic [7:0] bdat;
  logic [63:0] bits;

  assign bits = {msg_bytes, 3'b000};
  assign in_stall = (state != S_IDLE);

  always_comb begin
    bwr = 1'b0;
    bdat = 8'h00;
    if (state == S_IDLE && in_valid && has_byte) begin
      bwr = 1'b1;
      bdat = data_byte;
    end else if (state == S_PAD) begin
      bwr = 1'b1;
      if (pad_first) begin
        bdat = 8'h80;
      end else if (fill >= 6'd56 && !pad_spill) begin
        bdat = bits[{~fill[2:0], 3'b111} -: 8];
      end else begin
        bdat = 8'h00;
      end
    end
  end

  // Partial word under construction; written to memory when its fourth byte lands.
  logic [31:0] word_new;
  always_comb begin
    word_new = word_buf;
    case (fill[1:0])
      2'd0: word_new = {bdat, 24'h0};
      2'd1: word_new[23:16] = bdat;
      2'd2: word_new[15:8] = bdat;
      default: word_new[7:0] = bdat;
    endcase
  end

  sha256_round u_round (.v(v), .k(sha256_pkg::round_k(rnd)), .w(w_cur), .v_next(v_next));

  // Schedule word: the block word for rounds 0..15, else computed from the four words read.
  assign w_cur = (rnd < 6'd16) ? w16 :
                 sha256_pkg::sig1(w2) + w7 + sha256_pkg::sig0(w15) + w16;

  logic [3:0] wr_addr;
  always_comb begin
    case (state)
      S_RD1:   wr_addr = rnd[3:0] - 4'd2;
      S_RD2:   wr_addr = rnd[3:0] - 4'd7;
      S_RD3:   wr_addr = rnd[3:0] - 4'd15;
      default: wr_addr = rnd[3:0];
    endcase
  end

  // Control, datapath and memory updates.
  always_ff @(posedge clk) begin
    rdata <= wmem[wr_addr];
    hdata <= hmem[hidx];
    hval_q <= hvalid[hidx];
    if (bwr) begin
      word_buf <= word_new;
      if (fill[1:0] == 2'd3) begin
        wmem[fill[5:2]] <= word_new;
      end
    end
    if (state == S_ROUND && rnd >= 6'd16) begin
      wmem[rnd[3:0]] <= w_cur;
    end
    if (state == S_ADDW) begin
      hmem[hidx] <= (hval_q ? hdata : sha256_pkg::init_hash(hidx)) + v[255:224];
    end
    if (rst) begin
      state <= S_IDLE;
      fill <= '0;
      msg_bytes <= '0;
      finishing <= 1'b0;
      hvalid <= '0;
      out_valid <= 1'b0;
      pad_cnt <= '0;
      pad_first <= 1'b0;
      pad_spill <= 1'b0;
      rnd <= '0;
      hidx <= '0;
    end else begin
      if (bwr) begin
        fill <= fill + 6'd1;
        if (state == S_PAD) begin
          pad_first <= 1'b0;
          if (fill == 6'd63) begin
            pad_spill <= 1'b0;
          end else if (pad_first && fill >= 6'd56) begin
            pad_spill <= 1'b1;
          end
          if (!pad_first && !pad_spill && fill >= 6'd56) begin
            pad_cnt <= pad_cnt + 4'd1;
          end
        end
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (has_byte) begin
              msg_bytes <= msg_bytes + 61'd1;
            end
            finishing <= last;
            pad_first <= last;
            pad_cnt <= '0;
            if (has_byte && fill == 6'd63) begin
              hidx <= '0;
              state <= S_LOAD;
            end else if (last) begin
              state <= S_PAD;
            end
          end
        end
        S_PAD: begin
          if (fill == 6'd63) begin
            hidx <= '0;
            state <= S_LOAD;
          end
        end
        // Read H[hidx] into the working variables, shifting each in at h so that H0 ends in a.
        S_LOAD: state <= S_LOADW;
        S_LOADW: begin
          v <= {v[223:0], hval_q ? hdata : sha256_pkg::init_hash(hidx)};
          hidx <= hidx + 3'd1;
          if (hidx == 3'd7) begin
            rnd <= '0;
            state <= S_RD1;
          end else begin
            state <= S_LOAD;
          end
        end
        // Read schedule words w[t-2], w[t-7], w[t-15], then w[t].
        S_RD1: state <= S_RD2;
        S_RD2: begin
          w2 <= rdata;
          state <= S_RD3;
        end
        S_RD3: begin
          w7 <= rdata;
          state <= S_RD4;
        end
        S_RD4: state <= S_ROUND;
        S_ROUND: begin
          v <= v_next;
          rnd <= rnd + 6'd1;
          if (rnd == 6'd63) begin
            hidx <= '0;
            state <= S_ADD;
          end else begin
            state <= S_RD1;
          end
        end
        // Add working variables back into the hash, a first.
        S_ADD: state <= S_ADDW;
        S_ADDW: begin
          hvalid[hidx] <= 1'b1;
          v <= {v[223:0], v[255:224]};
          hidx <= hidx + 3'd1;
          if (hidx == 3'd7) begin
            if (finishing && pad_cnt == 4'd8) begin
              state <= S_HRD;
            end else if (finishing) begin
              state <= S_PAD;
            end else begin
              state <= S_IDLE;
            end
          end else begin
            state <= S_ADD;
          end
        end
        // Digest output: read each hash word and hold it until taken.
        S_HRD: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            hidx <= hidx + 3'd1;
            if (hidx == 3'd7) begin
              hvalid <= '0;
              msg_bytes <= '0;
              fill <= '0;
              finishing <= 1'b0;
              state <= S_IDLE;
            end else begin
              state <= S_HRD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The w15 word is captured in the cycle before the round; w16 is the read data in
  // the round cycle itself.
  always_ff @(posedge clk) begin
    if (state == S_RD4) begin
      w15 <= rdata;
    end
  end
  always_comb begin
    w16 = rdata;
  end

  assign digest_word = hval_q ? hdata : sha256_pkg::init_hash(hidx);
  assign word_index  = hidx;
  assign final_word  = (hidx == 3'd7);

  // Input is never taken while a block is being compressed.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_ROUND) |-> in_stall)
    else $error("input taken during compression");

  // Round counter only advances in the round state.
  assert property (@(posedge clk) disable iff (rst)
    (state != S_ROUND && state != S_IDLE && state != S_OUT) |=> $stable(rnd) || rnd == 6'd0)
    else $error("round counter moved outside rounds");

  // A result is only shown while the digest is being sent.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (state == S_OUT))
    else $error("result outside output phase");

endmodule

@@ tb/sha256_digest_checker.sv @@
// Checker for the SHA-256 byte-stream hasher: watches both channels, keeps its own
// digest predictor and compares every digest word. Depends on sha256_pkg for word_t.
`timescale 1ns / 100ps

module sha256_digest_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        has_byte,
  input  logic        last,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] digest_word,
  input  logic [2:0]  word_index,
  input  logic        final_word,
  output int          fail_count,
  output int          pending_words
);

  typedef struct packed {
    sha256_pkg::word_t digest;
    logic [2:0]        index;
    logic              is_final;
  } digest_word_t;

  localparam sha256_pkg::word_t IvTable [8] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19};
  localparam sha256_pkg::word_t KTable [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  sha256_pkg::word_t run_hash [8];
  logic [7:0]        block_buf [64];
  logic [5:0]        fill_pos;
  logic [60:0]       byte_total;
  digest_word_t      digest_q [$];

  function automatic sha256_pkg::word_t ror32(input sha256_pkg::word_t x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // Fold the 64 gathered bytes into the running hash.
  task automatic fold_block();
    sha256_pkg::word_t w [64];
    sha256_pkg::word_t v [8];
    sha256_pkg::word_t t1, t2;
    for (int i = 0; i < 16; i++)
      w[i] = {block_buf[4*i], block_buf[4*i+1], block_buf[4*i+2], block_buf[4*i+3]};
    for (int i = 16; i < 64; i++)
      w[i] = (ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
           + (ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
    v = run_hash;
    for (int t = 0; t < 64; t++) begin
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + KTable[t] + w[t];
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int j = 0; j < 8; j++) run_hash[j] += v[j];
  endtask

  task automatic absorb_byte(input logic [7:0] b);
    block_buf[fill_pos] = b;
    fill_pos++;
    if (fill_pos == 0) fold_block();
  endtask

  // Pad, append the bit length and queue the eight digest words.
  task automatic finish_message();
    logic [63:0] bit_len;
    bit_len = {byte_total, 3'b000};
    absorb_byte(8'h80);
    while (fill_pos != 56) absorb_byte(8'h00);
    for (int j = 0; j < 8; j++) absorb_byte(bit_len[63-8*j -: 8]);
    for (int j = 0; j < 8; j++) digest_q.push_back('{run_hash[j], 3'(j), j == 7});
    run_hash = IvTable;
    fill_pos = '0;
    byte_total = '0;
  endtask

  always @(posedge clk) begin
    digest_word_t exp_w;
    if (rst) begin
      run_hash = IvTable;
      fill_pos = '0;
      byte_total = '0;
      digest_q.delete();
      fail_count = 0;
    end else begin
      // Result side first; a new digest cannot appear in the same cycle as its last byte.
      if (out_valid && !out_stall) begin
        if (digest_q.size() == 0) begin
          $display("%0t: unexpected digest word %h index %0d", $time, digest_word, word_index);
          fail_count++;
        end else begin
          exp_w = digest_q.pop_front();
          if (exp_w !== {digest_word, word_index, final_word}) begin
            $display("%0t: digest mismatch: expected %h/%0d/%0b actual %h/%0d/%0b", $time,
                     exp_w.digest, exp_w.index, exp_w.is_final,
                     digest_word, word_index, final_word);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (has_byte) begin
          absorb_byte(data_byte);
          byte_total++;
        end
        if (last) finish_message();
      end
    end
    pending_words = digest_q.size();
  end
endmodule

@@ tb/tb.sv @@
// Testbench top for sha256_byte_stream_hasher_core: drives byte messages with bursty
// timing and random output stalls. Depends on the core and sha256_digest_checker.
`timescale 1ns / 100ps

module tb;
  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] data_byte = '0;
  logic       has_byte = 1'b0;
  logic       last = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        final_word;
  int          fail_count;
  int          pending_words;
  int          cycle_count = 0;
  logic        long_hold = 1'b0;

  always #5 clk = ~clk;

  sha256_byte_stream_hasher_core u_dut (.*);
  sha256_digest_checker u_chk (.*);

  // Timeout guard.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 2000000) begin
      $display("sha256_byte_stream_hasher_core verification failed");
      $finish;
    end
  end

  // Receiver stall pattern, with one long hold-off.
  always @(posedge clk) begin
    if (long_hold) out_stall <= 1'b1;
    else case (cycle_count[9:8])
      2'd0: out_stall <= 1'b0;
      2'd1: out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 1) == 0);
    endcase
  end

  initial begin
    repeat (3000) @(posedge clk);
    long_hold = 1'b1;
    repeat (2500) @(posedge clk);
    long_hold = 1'b0;
  end

  // Offer one word and hold it until accepted, with an occasional random gap afterwards.
  task automatic send_word(input logic [7:0] b, input logic hb, input logic lst);
    in_valid  <= 1'b1;
    data_byte <= b;
    has_byte  <= hb;
    last      <= lst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if ($urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic send_message(input int len, input logic mode);
    for (int i = 0; i < len; i++)
      send_word(mode ? 8'($urandom) : 8'(i), 1'b1, (i == len - 1));
    if (len == 0) send_word(8'h00, 1'b0, 1'b1);
  endtask

  initial begin
    int len;
    int sent;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // Directed: empty message, extremes, idle words, byte-less last, padding edges.
    send_word(8'h00, 1'b0, 1'b1);
    send_word(8'hFF, 1'b1, 1'b0);
    send_word(8'h00, 1'b0, 1'b0);
    send_word(8'h00, 1'b1, 1'b1);
    send_word(8'hA5, 1'b1, 1'b0);
    send_word(8'h5A, 1'b1, 1'b0);
    send_word(8'h00, 1'b0, 1'b1);
    send_word(8'h00, 1'b0, 1'b1);
    // Pause until all digests are out.
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    send_message(55, 1'b1);
    send_message(56, 1'b1);
    send_message(64, 1'b0);
    // Random messages, mostly short, some crossing block boundaries.
    sent = 0;
    while (sent < 270) begin
      case ($urandom_range(0, 9))
        0: len = 0;
        1, 2: len = $urandom_range(50, 70);
        3: len = $urandom_range(110, 130);
        default: len = $urandom_range(1, 20);
      endcase
      if ($urandom_range(0, 5) == 0) begin
        send_word(8'($urandom), 1'b0, 1'b0);
        sent += 1;
      end
      if (len > 0 && $urandom_range(0, 3) == 0) begin
        send_message(len, 1'b1);
      end else if (len > 0) begin
        for (int i = 0; i < len; i++) send_word(8'($urandom), 1'b1, 1'b0);
        send_word(8'h00, 1'b0, 1'b1);
      end else begin
        send_word(8'h00, 1'b0, 1'b1);
      end
      sent += len + 1;
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) $display("sha256_byte_stream_hasher_core verification clean");
    else $display("sha256_byte_stream_hasher_core verification failed");
    $finish;
  end
endmodule

@@ files.f @@
hdl/sha256_pkg.sv
hdl/sha256_round.sv
hdl/sha256_byte_stream_hasher_core.sv
tb/sha256_digest_checker.sv
tb/tb.sv
